// ===== hw/rtl/font_source_byte_tokenizer_defines.svh =====
// Assertion macros shared by the tokenizer RTL.
// No dependencies; the including module must have clk_i and rst_ni.
`ifndef FONT_SOURCE_BYTE_TOKENIZER_DEFINES_SVH
`define FONT_SOURCE_BYTE_TOKENIZER_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define FSBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define FSBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fsbt_pkg.sv =====
// Types shared by the byte tokenizer modules.
// No dependencies.
package fsbt_pkg;

  typedef enum logic [3:0] {
    KIND_EOF    = 4'd0,
    KIND_EQ     = 4'd1,
    KIND_COMMA  = 4'd2,
    KIND_SEMI   = 4'd3,
    KIND_LBRACE = 4'd4,
    KIND_RBRACE = 4'd5,
    KIND_CHAR   = 4'd6,
    KIND_INT    = 4'd7,
    KIND_SCHAR  = 4'd8,
    KIND_SEND   = 4'd9,
    KIND_JUNK   = 4'd10,
    KIND_ERR    = 4'd11
  } kind_e;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_CMT    = 4'd1,
    MODE_COPEN  = 4'd2,
    MODE_CESC   = 4'd3,
    MODE_COCT   = 4'd4,
    MODE_CCLOSE = 4'd5,
    MODE_STR    = 4'd6,
    MODE_SESC   = 4'd7,
    MODE_SOCT   = 4'd8,
    MODE_INT    = 4'd9
  } mode_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } fsbt_in_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic        pixel_on;
    logic [15:0] line;
    logic        last;
  } fsbt_res_t;

  // Up to two results produced by one byte, in order a then b.
  typedef struct packed {
    logic      a_vld;
    fsbt_res_t a;
    logic      b_vld;
    fsbt_res_t b;
  } fsbt_push_t;

endpackage

// ===== hw/rtl/fsbt_chan_if.sv =====
// Valid/ready channel carrying one word of type data_t.
// Used with fsbt_pkg::fsbt_in_t and fsbt_pkg::fsbt_res_t.
interface fsbt_chan_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/fsbt_lexer.sv =====
// Input register, lexer state and the single-pass next-state logic.
// Depends on fsbt_pkg, fsbt_chan_if and the shared assertion macros.
`include "font_source_byte_tokenizer_defines.svh"

module fsbt_lexer (
  input  logic                clk_i,
  input  logic                rst_ni,
  fsbt_chan_if.sink           src_i,
  input  logic                room_i,
  output fsbt_pkg::fsbt_push_t push_o
);
  import fsbt_pkg::*;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_LBR  = 8'h7B;
  localparam logic [7:0] CH_RBR  = 8'h7D;

  function automatic fsbt_res_t mk_res(kind_e k, logic [31:0] v, logic p, logic [15:0] ln);
    fsbt_res_t r;
    r.kind     = k;
    r.value    = v;
    r.pixel_on = p;
    r.line     = ln;
    r.last     = 1'b0;
    return r;
  endfunction

  function automatic fsbt_res_t mk_schar(logic [7:0] ch, logic [15:0] ln);
    return mk_res(KIND_SCHAR, {24'd0, ch}, !(ch == CH_SP || ch == CH_DASH), ln);
  endfunction

  logic        in_vld_q;
  fsbt_in_t    in_q;
  logic        fire;

  mode_e       mode_q, mode_d, mode_mid;
  logic [31:0] accum_q, acc_d, acc_mid;
  logic [1:0]  oct_q, oct_d, oct_mid;
  logic [15:0] line_q, line_nl;
  logic        skip;

  logic [7:0]  b;
  logic        eof;
  logic        is_dig;
  logic        is_oct;
  logic [35:0] acc_x10;
  logic [31:0] acc_o8;

  logic        a_raw, b_raw;
  fsbt_res_t   res_a, res_b;

  assign fire        = in_vld_q && room_i;
  assign src_i.ready = !in_vld_q || fire;

  assign b      = in_q.byte_value;
  assign eof    = in_q.end_of_input;
  assign is_dig = (b >= CH_0) && (b <= CH_9);
  assign is_oct = (b[7:3] == 5'b00110);

  // accum * 10 + digit, four bits wider than accum_q to spot overflow.
  assign acc_x10 = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} + {32'd0, b[3:0]};
  assign acc_o8  = {accum_q[28:0], b[2:0]};

  // Phase one: an integer or octal escape either absorbs the byte or closes.
  always_comb begin : p_phase1
    mode_mid = mode_q;
    acc_mid  = accum_q;
    oct_mid  = oct_q;
    skip     = 1'b0;
    unique case (mode_q) inside
      MODE_INT: begin
        if (!eof && is_dig) begin
          skip    = 1'b1;
          acc_mid = (|acc_x10[35:32]) ? 32'hFFFF_FFFF : acc_x10[31:0];
        end else begin
          mode_mid = MODE_IDLE;
        end
      end
      MODE_SOCT, MODE_COCT: begin
        if (!eof && is_oct) begin
          skip    = 1'b1;
          acc_mid = acc_o8;
          oct_mid = oct_q + 2'd1;
          if (oct_q == 2'd2) begin
            oct_mid  = 2'd0;
            mode_mid = (mode_q == MODE_SOCT) ? MODE_STR : MODE_CCLOSE;
          end
        end else begin
          oct_mid  = 2'd0;
          mode_mid = (mode_q == MODE_SOCT) ? MODE_STR : MODE_CCLOSE;
        end
      end
      default: begin
      end
    endcase
    line_nl = line_q;
    if (!skip && !eof && b == CH_NL && line_q != 16'hFFFF) begin
      line_nl = line_q + 16'd1;
    end
  end

  // Phase two, next state: the byte handled in the mode left by phase one.
  always_comb begin : p_next
    mode_d = mode_mid;
    acc_d  = acc_mid;
    oct_d  = oct_mid;
    if (!skip) begin
      unique case (mode_mid) inside
        MODE_CMT: begin
          if (eof || b == CH_NL) begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_COPEN: begin
          if (eof || b == CH_SQ) begin
            mode_d = MODE_IDLE;
          end else if (b == CH_BSL) begin
            mode_d = MODE_CESC;
          end else begin
            acc_d  = {24'd0, b};
            mode_d = MODE_CCLOSE;
          end
        end
        MODE_CESC: begin
          if (eof || b == CH_NL || b == CH_CR) begin
            mode_d = MODE_IDLE;
          end else if (is_oct) begin
            acc_d  = {29'd0, b[2:0]};
            oct_d  = 2'd1;
            mode_d = MODE_COCT;
          end else begin
            acc_d  = {24'd0, b};
            mode_d = MODE_CCLOSE;
          end
        end
        MODE_CCLOSE: begin
          mode_d = MODE_IDLE;
        end
        MODE_STR: begin
          if (eof || b == CH_DQ || b == CH_NL) begin
            mode_d = MODE_IDLE;
          end else if (b == CH_BSL) begin
            mode_d = MODE_SESC;
          end
        end
        MODE_SESC: begin
          if (eof || b == CH_NL || b == CH_CR) begin
            mode_d = MODE_IDLE;
          end else if (is_oct) begin
            acc_d  = {29'd0, b[2:0]};
            oct_d  = 2'd1;
            mode_d = MODE_SOCT;
          end else begin
            mode_d = MODE_STR;
          end
        end
        default: begin
          mode_d = MODE_IDLE;
          if (!eof) begin
            unique case (b) inside
              CH_HASH: mode_d = MODE_CMT;
              CH_SQ:   mode_d = MODE_COPEN;
              CH_DQ:   mode_d = MODE_STR;
              [CH_0:CH_9]: begin
                acc_d  = {28'd0, b[3:0]};
                mode_d = MODE_INT;
              end
              default: begin
              end
            endcase
          end
        end
      endcase
    end
  end

  // Outputs: the closing result of phase one and the result of phase two.
  always_comb begin : p_out
    a_raw = ((mode_q == MODE_INT) && (mode_mid == MODE_IDLE)) ||
            ((mode_q == MODE_SOCT) && (mode_mid == MODE_STR));
    if (mode_q == MODE_INT) begin
      res_a = mk_res(KIND_INT, acc_mid, 1'b0, line_q);
    end else begin
      res_a = mk_schar(acc_mid[7:0], line_q);
    end

    b_raw = 1'b0;
    res_b = mk_res(KIND_ERR, 32'd0, 1'b0, line_nl);
    if (!skip) begin
      unique case (mode_mid) inside
        MODE_CMT: begin
          if (eof) begin
            b_raw = 1'b1;
            res_b = mk_res(KIND_EOF, 32'd0, 1'b0, line_nl);
          end
        end
        MODE_COPEN: begin
          b_raw = eof || b == CH_SQ;
        end
        MODE_CESC, MODE_SESC: begin
          if (eof || b == CH_NL || b == CH_CR) begin
            b_raw = 1'b1;
          end else if (mode_mid == MODE_SESC && !is_oct) begin
            b_raw = 1'b1;
            res_b = mk_schar(b, line_nl);
          end
        end
        MODE_CCLOSE: begin
          b_raw = 1'b1;
          if (!eof && b == CH_SQ) begin
            res_b = mk_res(KIND_CHAR, acc_mid, 1'b0, line_nl);
          end
        end
        MODE_STR: begin
          if (eof || b == CH_DQ) begin
            b_raw = 1'b1;
            res_b = mk_res(KIND_SEND, 32'd0, 1'b0, line_nl);
          end else if (b == CH_NL) begin
            b_raw = 1'b1;
          end else if (b != CH_BSL) begin
            b_raw = 1'b1;
            res_b = mk_schar(b, line_nl);
          end
        end
        default: begin
          if (eof) begin
            b_raw = 1'b1;
            res_b = mk_res(KIND_EOF, 32'd0, 1'b0, line_nl);
          end else begin
            b_raw = 1'b1;
            unique case (b) inside
              CH_SP, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR, CH_HASH, CH_SQ, CH_DQ,
              [CH_0:CH_9]: b_raw = 1'b0;
              CH_EQ:    res_b = mk_res(KIND_EQ, 32'd0, 1'b0, line_nl);
              CH_COMMA: res_b = mk_res(KIND_COMMA, 32'd0, 1'b0, line_nl);
              CH_SEMI:  res_b = mk_res(KIND_SEMI, 32'd0, 1'b0, line_nl);
              CH_LBR:   res_b = mk_res(KIND_LBRACE, 32'd0, 1'b0, line_nl);
              CH_RBR:   res_b = mk_res(KIND_RBRACE, 32'd0, 1'b0, line_nl);
              default:  res_b = mk_res(KIND_JUNK, 32'd0, 1'b0, line_nl);
            endcase
          end
        end
      endcase
    end
    res_a.last = !b_raw;
    res_b.last = 1'b1;
  end

  assign push_o.a_vld = fire && a_raw;
  assign push_o.a     = res_a;
  assign push_o.b_vld = fire && b_raw;
  assign push_o.b     = res_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= MODE_IDLE;
      accum_q  <= 32'd0;
      oct_q    <= 2'd0;
      line_q   <= 16'd1;
    end else begin
      if (src_i.ready) begin
        in_vld_q <= src_i.valid;
      end
      if (fire) begin
        mode_q  <= mode_d;
        accum_q <= acc_d;
        oct_q   <= oct_d;
        line_q  <= line_nl;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_i.valid && src_i.ready) begin
      in_q <= src_i.data;
    end
  end

  `FSBT_ASSERT(a_oct_range, oct_q != 2'd3, "octal digit count out of range")
  `FSBT_ASSERT(a_oct_mode, (mode_q == MODE_SOCT || mode_q == MODE_COCT) |-> (oct_q != 2'd0), "octal mode without digits")
  `FSBT_ASSERT(a_line_nonzero, line_q != 16'd0, "line count dropped to zero")
  `FSBT_ASSERT(a_first_only_close, (mode_q == MODE_IDLE || mode_q == MODE_STR) |-> !a_raw, "closing result outside integer or escape")

endmodule

// ===== hw/rtl/fsbt_res_queue.sv =====
// Queue: takes up to two results a cycle; one word leaves per ready cycle.
// Depends on fsbt_pkg, fsbt_chan_if and the shared assertion macros.
`include "font_source_byte_tokenizer_defines.svh"

module fsbt_res_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fsbt_pkg::fsbt_push_t push_i,
  output logic                 room_o,
  fsbt_chan_if.source          res_o
);
  import fsbt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  fsbt_res_t       mem_q [Depth];
  logic [PtrW-1:0] head_q, tail_q, tail_p1;
  logic [CntW-1:0] cnt_q, push_n;
  logic            pop;
  fsbt_res_t       first;

  assign tail_p1 = ptr_inc(tail_q);
  assign push_n  = CntW'(push_i.a_vld) + CntW'(push_i.b_vld);
  assign pop     = res_o.valid && res_o.ready;
  assign first   = push_i.a_vld ? push_i.a : push_i.b;

  // Room for the worst case of two results, judged on the registered count.
  assign room_o      = (cnt_q <= CntW'(Depth - 2));
  assign res_o.valid = (cnt_q != '0);
  assign res_o.data  = mem_q[head_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_q + push_n - CntW'(pop);
      if (pop) begin
        head_q <= ptr_inc(head_q);
      end
      if (push_n == CntW'(1)) begin
        tail_q <= tail_p1;
      end else if (push_n == CntW'(2)) begin
        tail_q <= ptr_inc(tail_p1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != '0) begin
      mem_q[tail_q] <= first;
    end
    if (push_i.a_vld && push_i.b_vld) begin
      mem_q[tail_p1] <= push_i.b;
    end
  end

  `FSBT_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "result queue count beyond depth")
  `FSBT_ASSERT(a_push_room, (push_n != '0) |-> room_o, "push into queue without room")
  `FSBT_ASSERT_NEXT(a_drain, pop && push_n == '0 && cnt_q == CntW'(1), !res_o.valid, "queue not empty after last word left")

endmodule

// ===== hw/rtl/font_source_byte_tokenizer.sv =====
// Top level of the source byte tokenizer: lexer plus result queue.
// Depends on fsbt_pkg, fsbt_chan_if, fsbt_lexer and fsbt_res_queue.
//
//   Channel  Direction  Word type               Meaning
//   src_i    in         fsbt_pkg::fsbt_in_t     one source byte or end-of-input mark
//   res_o    out        fsbt_pkg::fsbt_res_t    one token result, last marks final one
//
// Each byte is accepted into an input register and processed from there, so a
// new byte can be taken every cycle while the queue has room; its zero to two
// results are written into the result queue together, and res_o reads them there.
// The output port moves one result word per cycle while res_o.ready is high;
// a byte with two results uses two words; the queue absorbs up to ResDepth words.
// Reset is asynchronous, active low; it puts the lexer idle with line count one.
// A stall on res_o backs up the queue; once fewer than two queue entries are
// free, the held byte waits in the input register and src_i.ready stays low
// until the queue drains. No result is ever dropped.
`include "font_source_byte_tokenizer_defines.svh"

module font_source_byte_tokenizer #(
  // Result queue depth in words, two or more.
  parameter int unsigned ResDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fsbt_chan_if.sink   src_i,
  fsbt_chan_if.source res_o
);
  import fsbt_pkg::*;

  // Results of the byte being processed, and whether the queue can take them.
  fsbt_push_t push;
  logic       room;

  // Output handshake conditions used by the checks below.
  logic       pop_open;
  logic       res_stall;

  // The lexer holds the mode, the accumulator for integers and octal escapes,
  // the octal digit count and the saturating line counter. An integer, or an
  // octal escape with fewer than three digits, is closed by the byte after it,
  // which is then handled in the same cycle; that is where the second result comes from.
  fsbt_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .src_i  (src_i),
    .room_i (room),
    .push_o (push)
  );

  // The queue keeps results in order and parts the output handshake from the
  // input handshake.
  fsbt_res_queue #(
    .Depth (ResDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .res_o  (res_o)
  );

  assign pop_open  = res_o.valid && res_o.ready && !res_o.data.last;
  assign res_stall = res_o.valid && !res_o.ready;

  // A word leaving with last cleared is always followed by another one.
  `FSBT_ASSERT(a_last_follow, pop_open |=> res_o.valid, "result pair split by an empty queue")
  // Nothing reaches the queue while it lacks room for a pair.
  `FSBT_ASSERT(a_no_push_full, (push.a_vld || push.b_vld) |-> room, "result pushed without room")
  // A stalled output word stays put.
  `FSBT_ASSERT_NEXT(a_hold, res_stall, res_o.valid && $stable(res_o.data), "result changed")

endmodule
